// ===== hdl/plet_pkg.sv =====
// Shared types and constants of the pool LRU eviction tracker.
package plet_pkg;

    localparam int TAG_W     = 16;
    localparam int SIZE_W    = 48;
    localparam int LIMIT_W   = 48;
    localparam int THR_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_POOLS = 5;
    localparam int RESULT_CAP = 64;
    localparam int CAP_W     = $clog2(RESULT_CAP);

    localparam logic [THR_W-1:0]     THR_RESET = 16'd3686;
    localparam logic [CFG_IDX_W-1:0] CFG_THR   = 3'd5;

    localparam logic [2:0] K_REG    = 3'd0;
    localparam logic [2:0] K_UNREG  = 3'd1;
    localparam logic [2:0] K_RELOC  = 3'd2;
    localparam logic [2:0] K_TOUCH  = 3'd3;
    localparam logic [2:0] K_QUERY  = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SAME    = 3'd1;
    localparam logic [2:0] ST_NONE    = 3'd2;
    localparam logic [2:0] ST_BADPOOL = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam logic [1:0] PS_NONE = 2'd0;
    localparam logic [1:0] PS_REQ  = 2'd1;
    localparam logic [1:0] PS_HIT  = 2'd2;

    localparam logic [1:0] TS_REQ  = 2'd0;
    localparam logic [1:0] TS_ZERO = 2'd1;
    localparam logic [1:0] TS_WALK = 2'd2;

    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_SCAN      = 4'd2;
    localparam logic [3:0] OP_REG_WR    = 4'd3;
    localparam logic [3:0] OP_SUB       = 4'd4;
    localparam logic [3:0] OP_UNL_RD    = 4'd5;
    localparam logic [3:0] OP_UNL_WR    = 4'd6;
    localparam logic [3:0] OP_MOVE      = 4'd7;
    localparam logic [3:0] OP_APP1      = 4'd8;
    localparam logic [3:0] OP_APP2      = 4'd9;
    localparam logic [3:0] OP_PRESS     = 4'd10;
    localparam logic [3:0] OP_EMIT      = 4'd11;
    localparam logic [3:0] OP_WALK_RD   = 4'd12;
    localparam logic [3:0] OP_WALK_EMIT = 4'd13;

    typedef struct packed {
        logic [2:0]        kind;
        logic [TAG_W-1:0]  entry_tag;
        logic [2:0]        pool;
        logic [SIZE_W-1:0] buf_size;
        logic [SIZE_W-1:0] free_goal;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [TAG_W-1:0]  out_tag;
        logic [2:0]        out_pool;
        logic [SIZE_W-1:0] pool_bytes_used;
        logic              over_threshold;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] status;
        logic [1:0] psrc;
        logic [1:0] tsrc;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       pool_ok;
        logic       q_empty;
        logic       scan_done;
        logic       hit;
        logic       free_ok;
        logic       same_pool;
        logic       walk_last;
        logic       out_free;
    } sts_t;

endpackage

// ===== hdl/pool_lru_eviction_tracker_core.sv =====
// Top level of the pool LRU eviction tracker.
// Tracks up to MAX_ENTRIES tagged buffers in five pools, each with its own recency list
// and saturating byte count. One transaction is worked at a time; the next is taken the
// cycle after the final result is loaded into the output register. Register, unregister,
// relocate and touch first run a tag lookup that reads the entry memory one slot per
// cycle and then the list edits. A bad pool (register, relocate, query), an unknown kind
// or an empty query goes straight to the result; a query walk steps along the newer-link
// memory one candidate at a time. A full output register holds each result back until it
// is free. Valid bits clear at reset, so no clearing pass is needed.
module pool_lru_eviction_tracker_core #(
    parameter int MAX_ENTRIES = 64,
    parameter int TAG_BITS    = 16,
    parameter int SIZE_BITS   = 48
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  plet_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output plet_pkg::out_item_t            out_data,
    input  logic                           cfg_write,
    input  logic [plet_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [plet_pkg::LIMIT_W-1:0]   cfg_data
);
    import plet_pkg::*;

    cmd_t cmd;
    sts_t sts;

    plet_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    plet_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .TAG_BITS    (TAG_BITS),
        .SIZE_BITS   (SIZE_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== hdl/plet_ctrl.sv =====
// Sequencing state machine of the pool LRU eviction tracker.
module plet_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  plet_pkg::sts_t sts,
    output plet_pkg::cmd_t cmd
);
    import plet_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_REGWR  = 4'd4;
    localparam logic [3:0] S_SUB    = 4'd5;
    localparam logic [3:0] S_UNLRD  = 4'd6;
    localparam logic [3:0] S_UNLWR  = 4'd7;
    localparam logic [3:0] S_MOVE   = 4'd8;
    localparam logic [3:0] S_APP1   = 4'd9;
    localparam logic [3:0] S_APP2   = 4'd10;
    localparam logic [3:0] S_PRESS  = 4'd11;
    localparam logic [3:0] S_EMIT   = 4'd12;
    localparam logic [3:0] S_WRD    = 4'd13;
    localparam logic [3:0] S_WEMIT  = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [2:0] st_reg, st_next;
    logic [1:0] ps_reg, ps_next;
    logic [1:0] ts_reg, ts_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        ps_next    = ps_reg;
        ts_next    = ts_reg;
        cmd.op     = OP_NOP;
        cmd.status = st_reg;
        cmd.psrc   = ps_reg;
        cmd.tsrc   = ts_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ts_next = TS_REQ;
                if (sts.kind > K_QUERY)
                begin
                    st_next    = ST_SAME;
                    ps_next    = PS_NONE;
                    state_next = S_PRESS;
                end
                else if (!sts.pool_ok && (sts.kind == K_REG || sts.kind == K_RELOC ||
                                          sts.kind == K_QUERY))
                begin
                    st_next    = ST_BADPOOL;
                    ps_next    = PS_REQ;
                    state_next = S_PRESS;
                end
                else if (sts.kind == K_QUERY)
                begin
                    ps_next    = PS_REQ;
                    st_next    = sts.q_empty ? ST_NONE : ST_OK;
                    ts_next    = sts.q_empty ? TS_ZERO : TS_WALK;
                    state_next = S_PRESS;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (sts.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_PRESS;
                if (sts.kind == K_REG)
                begin
                    if (sts.hit)
                    begin
                        st_next = ST_SAME;
                        ps_next = PS_HIT;
                    end
                    else if (!sts.free_ok)
                    begin
                        st_next = ST_FULL;
                        ps_next = PS_REQ;
                    end
                    else
                    begin
                        st_next    = ST_OK;
                        ps_next    = PS_REQ;
                        state_next = S_REGWR;
                    end
                end
                else if (!sts.hit)
                begin
                    st_next = ST_NONE;
                    ps_next = PS_NONE;
                end
                else if (sts.kind == K_UNREG)
                begin
                    st_next    = ST_OK;
                    ps_next    = PS_HIT;
                    state_next = S_SUB;
                end
                else if (sts.kind == K_RELOC)
                begin
                    if (sts.same_pool)
                    begin
                        st_next = ST_SAME;
                        ps_next = PS_HIT;
                    end
                    else
                    begin
                        st_next    = ST_OK;
                        ps_next    = PS_REQ;
                        state_next = S_SUB;
                    end
                end
                else
                begin
                    st_next    = ST_OK;
                    ps_next    = PS_HIT;
                    state_next = S_UNLRD;
                end
            end
            S_REGWR:
            begin
                cmd.op     = OP_REG_WR;
                state_next = S_APP1;
            end
            S_SUB:
            begin
                cmd.op     = OP_SUB;
                state_next = S_UNLRD;
            end
            S_UNLRD:
            begin
                cmd.op     = OP_UNL_RD;
                state_next = S_UNLWR;
            end
            S_UNLWR:
            begin
                cmd.op = OP_UNL_WR;
                if (sts.kind == K_UNREG)
                begin
                    state_next = S_PRESS;
                end
                else if (sts.kind == K_RELOC)
                begin
                    state_next = S_MOVE;
                end
                else
                begin
                    state_next = S_APP1;
                end
            end
            S_MOVE:
            begin
                cmd.op     = OP_MOVE;
                state_next = S_APP1;
            end
            S_APP1:
            begin
                cmd.op     = OP_APP1;
                state_next = S_APP2;
            end
            S_APP2:
            begin
                cmd.op     = OP_APP2;
                state_next = S_PRESS;
            end
            S_PRESS:
            begin
                cmd.op     = OP_PRESS;
                state_next = (ts_reg == TS_WALK) ? S_WRD : S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            S_WRD:
            begin
                cmd.op     = OP_WALK_RD;
                state_next = S_WEMIT;
            end
            S_WEMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_WALK_EMIT;
                    state_next = sts.walk_last ? S_IDLE : S_WRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
            ps_reg    <= PS_NONE;
            ts_reg    <= TS_REQ;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            ps_reg    <= ps_next;
            ts_reg    <= ts_next;
        end
    end

endmodule

// ===== hdl/plet_dpath.sv =====
// Entry table, recency links, pool counters and result register of the tracker.
module plet_dpath #(
    parameter int MAX_ENTRIES = 64,
    parameter int TAG_BITS    = 16,
    parameter int SIZE_BITS   = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  plet_pkg::in_item_t                  in_data,
    input  logic                                cfg_write,
    input  logic [plet_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [plet_pkg::LIMIT_W-1:0]        cfg_data,
    input  plet_pkg::cmd_t                      cmd,
    output plet_pkg::sts_t                      sts,
    output logic                                out_valid,
    input  logic                                out_ready,
    output plet_pkg::out_item_t                 out_data
);
    import plet_pkg::*;

    localparam int AW     = $clog2(MAX_ENTRIES);
    localparam int IW     = $clog2(MAX_ENTRIES + 1);
    localparam int PROD_W = THR_W + LIMIT_W;
    localparam int CMP_W  = (SIZE_BITS + 12 > PROD_W) ? SIZE_BITS + 12 : PROD_W;
    localparam logic [IW-1:0] NIL = IW'(MAX_ENTRIES);

    function automatic logic [SIZE_BITS-1:0] sat_add(input logic [SIZE_BITS-1:0] a,
                                                     input logic [SIZE_BITS-1:0] b);
        logic [SIZE_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SIZE_BITS] ? {SIZE_BITS{1'b1}} : s[SIZE_BITS-1:0];
    endfunction

    logic [TAG_BITS-1:0]  tag_mem   [MAX_ENTRIES];
    logic [2:0]           pool_mem  [MAX_ENTRIES];
    logic [SIZE_BITS-1:0] size_mem  [MAX_ENTRIES];
    logic [IW-1:0]        older_mem [MAX_ENTRIES];
    logic [IW-1:0]        newer_mem [MAX_ENTRIES];

    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [IW-1:0]          oldest_reg [NUM_POOLS];
    logic [IW-1:0]          newest_reg [NUM_POOLS];
    logic [SIZE_BITS-1:0]   bytes_reg  [NUM_POOLS];
    logic [LIMIT_W-1:0]     limit_reg  [NUM_POOLS];
    logic [THR_W-1:0]       thr_reg;

    logic [2:0]           kind_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    logic [2:0]           pool_reg;
    logic [SIZE_BITS-1:0] size_reg;
    logic [SIZE_W-1:0]    target_reg;

    logic [IW-1:0]        scan_cnt_reg;
    logic                 chk_vld_reg;
    logic [AW-1:0]        chk_idx_reg;
    logic                 hit_reg;
    logic                 free_reg;
    logic [AW-1:0]        hit_slot_reg;
    logic [AW-1:0]        free_slot_reg;
    logic [2:0]           hit_pool_reg;
    logic [SIZE_BITS-1:0] hit_size_reg;
    logic [2:0]           apool_reg;
    logic [IW-1:0]        t_reg;

    logic [TAG_BITS-1:0]  tag_rd_reg;
    logic [2:0]           pool_rd_reg;
    logic [SIZE_BITS-1:0] size_rd_reg;
    logic [IW-1:0]        older_rd_reg;
    logic [IW-1:0]        newer_rd_reg;

    logic [2:0]           res_status_reg;
    logic [TAG_W-1:0]     res_tag_reg;
    logic [2:0]           res_pool_reg;
    logic [SIZE_BITS-1:0] used_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 limnz_reg;
    logic [IW-1:0]        cur_reg;
    logic [SIZE_BITS-1:0] freed_reg;
    logic [CAP_W-1:0]     cnt_reg;

    logic                 out_valid_reg;
    out_item_t            out_reg;

    logic                 pool_ok;
    logic [2:0]           req_idx;
    logic [AW-1:0]        slot;
    logic                 p_ok;
    logic [2:0]           bsel;
    logic [SIZE_BITS-1:0] bytes_rd;
    logic [LIMIT_W-1:0]   lim_rd;
    logic                 over;
    logic [SIZE_BITS-1:0] freed_nx;
    logic                 walk_last;
    logic                 out_free;

    logic                 rec_re, rec_we;
    logic [AW-1:0]        rec_ra;
    logic [SIZE_BITS-1:0] rec_wsize;
    logic                 old_we;
    logic [AW-1:0]        old_wa;
    logic [IW-1:0]        old_wd;
    logic                 new_re, new_we;
    logic [AW-1:0]        new_ra, new_wa;
    logic [IW-1:0]        new_wd;

    assign pool_ok  = (pool_reg < 3'(NUM_POOLS));
    assign req_idx  = pool_ok ? pool_reg : 3'd0;
    assign slot     = hit_reg ? hit_slot_reg : free_slot_reg;
    assign p_ok     = (cmd.psrc == PS_HIT) || (cmd.psrc == PS_REQ && pool_ok);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        case (cmd.op)
            OP_REG_WR, OP_SUB: bsel = apool_reg;
            OP_MOVE:           bsel = req_idx;
            OP_PRESS:          bsel = (cmd.psrc == PS_HIT) ? hit_pool_reg : req_idx;
            default:           bsel = 3'd0;
        endcase
    end

    assign bytes_rd = bytes_reg[bsel];
    assign lim_rd   = limit_reg[bsel];

    assign over = limnz_reg &&
                  (CMP_W'({used_reg, 12'b0}) > CMP_W'(prod_reg));

    assign freed_nx  = sat_add(freed_reg, size_rd_reg);
    assign walk_last = (newer_rd_reg == NIL) ||
                       (64'(freed_nx) >= 64'(target_reg)) ||
                       (cnt_reg == CAP_W'(RESULT_CAP - 1));

    always_comb
    begin
        sts.kind      = kind_reg;
        sts.pool_ok   = pool_ok;
        sts.q_empty   = (oldest_reg[req_idx] == NIL) || (target_reg == '0);
        sts.scan_done = (scan_cnt_reg == NIL) && !chk_vld_reg;
        sts.hit       = hit_reg;
        sts.free_ok   = free_reg;
        sts.same_pool = (hit_pool_reg == pool_reg);
        sts.walk_last = walk_last;
        sts.out_free  = out_free;
    end

    always_comb
    begin
        rec_re    = (cmd.op == OP_SCAN && scan_cnt_reg != NIL) || cmd.op == OP_WALK_RD;
        rec_ra    = (cmd.op == OP_SCAN) ? scan_cnt_reg[AW-1:0] : cur_reg[AW-1:0];
        rec_we    = (cmd.op == OP_REG_WR) || (cmd.op == OP_MOVE);
        rec_wsize = (cmd.op == OP_REG_WR) ? size_reg : hit_size_reg;

        old_we = 1'b0;
        old_wa = slot;
        old_wd = newest_reg[apool_reg];
        if (cmd.op == OP_UNL_WR)
        begin
            old_we = (newer_rd_reg != NIL);
            old_wa = newer_rd_reg[AW-1:0];
            old_wd = older_rd_reg;
        end
        else if (cmd.op == OP_APP1)
        begin
            old_we = 1'b1;
        end

        new_re = (cmd.op == OP_UNL_RD) || (cmd.op == OP_WALK_RD);
        new_ra = (cmd.op == OP_UNL_RD) ? slot : cur_reg[AW-1:0];
        new_we = 1'b0;
        new_wa = slot;
        new_wd = NIL;
        case (cmd.op)
            OP_UNL_WR:
            begin
                new_we = (older_rd_reg != NIL);
                new_wa = older_rd_reg[AW-1:0];
                new_wd = newer_rd_reg;
            end
            OP_APP1:
            begin
                new_we = 1'b1;
            end
            OP_APP2:
            begin
                new_we = (t_reg != NIL);
                new_wa = t_reg[AW-1:0];
                new_wd = IW'(slot);
            end
            default:
            begin
                new_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            tag_mem[slot]  <= tag_reg;
            pool_mem[slot] <= pool_reg;
            size_mem[slot] <= rec_wsize;
        end
        if (rec_re)
        begin
            tag_rd_reg  <= tag_mem[rec_ra];
            pool_rd_reg <= pool_mem[rec_ra];
            size_rd_reg <= size_mem[rec_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (old_we)
        begin
            older_mem[old_wa] <= old_wd;
        end
        if (cmd.op == OP_UNL_RD)
        begin
            older_rd_reg <= older_mem[slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (new_we)
        begin
            newer_mem[new_wa] <= new_wd;
        end
        if (new_re)
        begin
            newer_rd_reg <= newer_mem[new_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < NUM_POOLS; i++)
            begin
                oldest_reg[i] <= NIL;
                newest_reg[i] <= NIL;
                bytes_reg[i]  <= '0;
                limit_reg[i]  <= '0;
            end
            thr_reg       <= THR_RESET;
            scan_cnt_reg  <= '0;
            chk_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index < CFG_IDX_W'(NUM_POOLS))
                begin
                    limit_reg[cfg_index] <= cfg_data;
                end
                else if (cfg_index == CFG_THR)
                begin
                    thr_reg <= cfg_data[THR_W-1:0];
                end
            end

            if (cmd.op == OP_LOAD)
            begin
                scan_cnt_reg <= '0;
                chk_vld_reg  <= 1'b0;
                hit_reg      <= 1'b0;
                free_reg     <= 1'b0;
            end
            else if (cmd.op == OP_SCAN)
            begin
                if (scan_cnt_reg != NIL)
                begin
                    chk_vld_reg  <= 1'b1;
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                else
                begin
                    chk_vld_reg <= 1'b0;
                end
            end

            if (chk_vld_reg)
            begin
                if (valid_reg[chk_idx_reg] && tag_rd_reg == tag_reg && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                if (!valid_reg[chk_idx_reg] && !free_reg)
                begin
                    free_reg <= 1'b1;
                end
            end

            case (cmd.op)
                OP_REG_WR:
                begin
                    valid_reg[slot]      <= 1'b1;
                    bytes_reg[apool_reg] <= sat_add(bytes_rd, size_reg);
                end
                OP_SUB:
                begin
                    if (kind_reg == K_UNREG)
                    begin
                        valid_reg[slot] <= 1'b0;
                    end
                    bytes_reg[apool_reg] <= (bytes_rd > hit_size_reg) ?
                                            bytes_rd - hit_size_reg : '0;
                end
                OP_UNL_WR:
                begin
                    if (older_rd_reg == NIL)
                    begin
                        oldest_reg[apool_reg] <= newer_rd_reg;
                    end
                    if (newer_rd_reg == NIL)
                    begin
                        newest_reg[apool_reg] <= older_rd_reg;
                    end
                end
                OP_MOVE:
                begin
                    bytes_reg[req_idx] <= sat_add(bytes_rd, hit_size_reg);
                end
                OP_APP1:
                begin
                    if (newest_reg[apool_reg] == NIL)
                    begin
                        oldest_reg[apool_reg] <= IW'(slot);
                    end
                    newest_reg[apool_reg] <= IW'(slot);
                end
                default:
                begin
                end
            endcase

            if (cmd.op == OP_EMIT || cmd.op == OP_WALK_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            kind_reg   <= in_data.kind;
            tag_reg    <= TAG_BITS'(in_data.entry_tag);
            pool_reg   <= in_data.pool;
            size_reg   <= SIZE_BITS'(in_data.buf_size);
            target_reg <= in_data.free_goal;
            apool_reg  <= in_data.pool;
        end

        if (cmd.op == OP_SCAN)
        begin
            chk_idx_reg <= scan_cnt_reg[AW-1:0];
        end

        if (chk_vld_reg)
        begin
            if (valid_reg[chk_idx_reg] && tag_rd_reg == tag_reg && !hit_reg)
            begin
                hit_slot_reg <= chk_idx_reg;
                hit_pool_reg <= pool_rd_reg;
                hit_size_reg <= size_rd_reg;
                apool_reg    <= pool_rd_reg;
            end
            if (!valid_reg[chk_idx_reg] && !free_reg)
            begin
                free_slot_reg <= chk_idx_reg;
            end
        end

        if (cmd.op == OP_MOVE)
        begin
            apool_reg <= pool_reg;
        end

        if (cmd.op == OP_APP1)
        begin
            t_reg <= newest_reg[apool_reg];
        end

        if (cmd.op == OP_PRESS)
        begin
            res_status_reg <= cmd.status;
            res_tag_reg    <= (cmd.tsrc == TS_ZERO) ? '0 : TAG_W'(tag_reg);
            case (cmd.psrc)
                PS_REQ:  res_pool_reg <= pool_reg;
                PS_HIT:  res_pool_reg <= hit_pool_reg;
                default: res_pool_reg <= 3'd0;
            endcase
            used_reg  <= p_ok ? bytes_rd : '0;
            prod_reg  <= p_ok ? thr_reg * lim_rd : '0;
            limnz_reg <= p_ok && (lim_rd != '0);
            cur_reg   <= oldest_reg[req_idx];
            freed_reg <= '0;
            cnt_reg   <= '0;
        end

        if (cmd.op == OP_EMIT)
        begin
            out_reg.status          <= res_status_reg;
            out_reg.out_tag         <= res_tag_reg;
            out_reg.out_pool        <= res_pool_reg;
            out_reg.pool_bytes_used <= SIZE_W'(used_reg);
            out_reg.over_threshold  <= over;
            out_reg.last            <= 1'b1;
        end
        else if (cmd.op == OP_WALK_EMIT)
        begin
            out_reg.status          <= ST_OK;
            out_reg.out_tag         <= TAG_W'(tag_rd_reg);
            out_reg.out_pool        <= res_pool_reg;
            out_reg.pool_bytes_used <= SIZE_W'(used_reg);
            out_reg.over_threshold  <= over;
            out_reg.last            <= walk_last;
            cur_reg                 <= newer_rd_reg;
            freed_reg               <= freed_nx;
            cnt_reg                 <= cnt_reg + 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
